// ----- rtl/uau_pkg.sv -----
// shared types and constants for the unsigned arithmetic unit
// no dependencies
package uau_pkg;

    localparam int WIDTH = 32;
    localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_LT  = 3'd4,
        CMD_LE  = 3'd5,
        CMD_GT  = 3'd6,
        CMD_GE  = 3'd7
    } t_cmd;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic iterative;
        logic last;
    } t_dp_sts;

endpackage

// ----- rtl/uau_ctrl.sv -----
// sequencer for the arithmetic unit: input beat, iteration, output register handshake
// depends on uau_pkg
module uau_ctrl import uau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: o_cmd.load     = i_in_valid;
            ST_RUN:  o_cmd.step     = i_sts.iterative;
            ST_DONE: o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (!i_sts.iterative || i_sts.last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/uau_dp.sv -----
// datapath: operand registers, shift-add multiply, restoring divide, output register
// depends on uau_pkg
module uau_dp import uau_pkg::*; (
    input  logic             i_clk,
    input  t_dp_cmd          i_cmd,
    input  logic [2:0]       i_command,
    input  logic [WIDTH-1:0] i_operand_a,
    input  logic [WIDTH-1:0] i_operand_b,
    output t_dp_sts          o_sts,
    output logic [WIDTH-1:0] o_result_value,
    output logic [WIDTH-1:0] o_remainder_value,
    output logic             o_compare_true,
    output logic             o_status
);

    t_cmd             r_cmd;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;

    logic [WIDTH-1:0] r_res;
    logic [WIDTH-1:0] r_rem;
    logic             r_cmp;
    logic             r_st;

    logic [WIDTH:0]   div_shift;
    logic [WIDTH:0]   div_diff;
    logic             div_fits;
    logic             b_zero;

    logic [WIDTH-1:0] n_res;
    logic [WIDTH-1:0] n_rem;
    logic             n_cmp;
    logic             n_st;

    assign b_zero    = (r_b == '0);
    assign div_shift = {r_acc, r_q[WIDTH-1]};
    assign div_diff  = div_shift - {1'b0, r_b};
    assign div_fits  = (div_shift >= {1'b0, r_b});

    assign o_sts.iterative = (r_cmd == CMD_MUL) || ((r_cmd == CMD_DIV) && !b_zero);
    assign o_sts.last      = (r_cnt == CNT_W'(WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= t_cmd'(i_command);
            r_a   <= i_operand_a;
            r_b   <= i_operand_b;
            r_acc <= '0;
            r_cnt <= '0;
            if (t_cmd'(i_command) == CMD_MUL) begin
                r_q <= i_operand_b;
            end else begin
                r_q <= i_operand_a;
            end
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cmd == CMD_MUL) begin
                if (r_q[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[WIDTH-2:0], 1'b0};
                r_q <= {1'b0, r_q[WIDTH-1:1]};
            end else begin
                if (div_fits) begin
                    r_acc <= div_diff[WIDTH-1:0];
                end else begin
                    r_acc <= div_shift[WIDTH-1:0];
                end
                r_q <= {r_q[WIDTH-2:0], div_fits};
            end
        end
    end

    always_comb begin
        n_res = '0;
        n_rem = '0;
        n_cmp = 1'b0;
        n_st  = 1'b0;
        case (r_cmd)
            CMD_ADD: n_res = r_a + r_b;
            CMD_SUB: n_res = r_a - r_b;
            CMD_MUL: n_res = r_acc;
            CMD_DIV: begin
                if (b_zero) begin
                    n_st = 1'b1;
                end else begin
                    n_res = r_q;
                    n_rem = r_acc;
                end
            end
            CMD_LT:  n_cmp = (r_a < r_b);
            CMD_LE:  n_cmp = (r_a <= r_b);
            CMD_GT:  n_cmp = (r_a > r_b);
            default: n_cmp = (r_a >= r_b);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res <= n_res;
            r_rem <= n_rem;
            r_cmp <= n_cmp;
            r_st  <= n_st;
        end
    end

    assign o_result_value    = r_res;
    assign o_remainder_value = r_rem;
    assign o_compare_true    = r_cmp;
    assign o_status          = r_st;

endmodule

// ----- rtl/unsigned_arith_unit_with_divider_top.sv -----
// unsigned arithmetic unit: add, sub, shift-add multiply, restoring divide, compares
// multiply and nonzero divide run the one-bit-per-cycle shift loop in the datapath before
// the output register loads; other commands pass through the run state without iterating
// a new input is taken only after the output register loads; an output stall delays this
// synchronous active-low reset clears the sequencer and output valid; no clearing pass
// depends on uau_pkg, uau_ctrl, uau_dp
module unsigned_arith_unit_with_divider_top import uau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_command,
    input  logic [WIDTH-1:0] i_operand_a,
    input  logic [WIDTH-1:0] i_operand_b,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [WIDTH-1:0] o_result_value,
    output logic [WIDTH-1:0] o_remainder_value,
    output logic             o_compare_true,
    output logic             o_status
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    uau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    uau_dp u_dp (
        .i_clk             (i_clk),
        .i_cmd             (dp_cmd),
        .i_command         (i_command),
        .i_operand_a       (i_operand_a),
        .i_operand_b       (i_operand_b),
        .o_sts             (dp_sts),
        .o_result_value    (o_result_value),
        .o_remainder_value (o_remainder_value),
        .o_compare_true    (o_compare_true),
        .o_status          (o_status)
    );

endmodule

// ----- rtl/uau_checker.sv -----
// port-level checks for the arithmetic unit, bound to the top level
// depends on uau_pkg and unsigned_arith_unit_with_divider_top
module uau_checker import uau_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [WIDTH-1:0] o_result_value,
    input logic [WIDTH-1:0] o_remainder_value,
    input logic             o_compare_true,
    input logic             o_status
);

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_remainder_value) && $stable(o_compare_true) && $stable(o_status))
        else $error("stalled output beat changed");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_in_stall)
        else $error("input taken while an item is in flight");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !$rose(o_out_valid))
        else $error("output beat appeared one cycle after input beat");

    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_result_value == '0 && o_remainder_value == '0
            && !o_compare_true)
        else $error("divide by zero with nonzero results");

    a_cmp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_compare_true |-> o_result_value == '0
            && o_remainder_value == '0 && !o_status)
        else $error("compare result mixed with arithmetic result");

endmodule

bind unsigned_arith_unit_with_divider_top uau_checker u_uau_checker (.*);
